>>> rtl/core/nnc_pkg.sv
package nnc_pkg;

  localparam int NumOctaves   = 9;
  localparam int FreqFracBits = 8;
  localparam int RomNotes     = 108;
  localparam int LogFrac      = 24;

  localparam int FreqW  = 22;
  localparam int PitchW = 21;
  localparam int IdxW   = 7;
  localparam int PcW    = 4;
  localparam int OctW   = 4;
  localparam int CentsW = 15;
  localparam int ExpW   = 5;
  localparam int MantW  = 31;
  localparam int LogW   = ExpW + LogFrac;
  localparam int CW     = 43;

  localparam int TabDepth = 1 << IdxW;
  localparam int LastRaw  = NumOctaves * 12 - 1;
  localparam int LastNote = (LastRaw > RomNotes - 1) ? RomNotes - 1 :
                            (LastRaw < 0) ? 0 : LastRaw;

  localparam logic [FreqW-1:0] FreqLo = FreqW'(((1 << FreqFracBits) + 5) / 10);
  localparam logic [FreqW-1:0] FreqHi = FreqW'(10000 << FreqFracBits);

  typedef logic [19:0] centihz_t;
  typedef logic [FreqW-1:0] search_tab_t [TabDepth];
  typedef logic [LogW-1:0] log_tab_t [TabDepth];
  typedef logic [3:0] small_tab_t [TabDepth];

  localparam centihz_t CENTIHZ [RomNotes] = '{
    20'd1635, 20'd1732, 20'd1835, 20'd1945, 20'd2060, 20'd2183, 20'd2312, 20'd2450,
    20'd2596, 20'd2750, 20'd2914, 20'd3087, 20'd3270, 20'd3465, 20'd3671, 20'd3889,
    20'd4120, 20'd4365, 20'd4625, 20'd4900, 20'd5191, 20'd5500, 20'd5827, 20'd6174,
    20'd6541, 20'd6930, 20'd7342, 20'd7778, 20'd8241, 20'd8731, 20'd9250, 20'd9800,
    20'd10383, 20'd11000, 20'd11654, 20'd12347, 20'd13081, 20'd13859, 20'd14683,
    20'd15556, 20'd16481, 20'd17461, 20'd18500, 20'd19600, 20'd20765, 20'd22000,
    20'd23308, 20'd24694, 20'd26163, 20'd27718, 20'd29366, 20'd31113, 20'd32963,
    20'd34923, 20'd36999, 20'd39200, 20'd41530, 20'd44000, 20'd46616, 20'd49388,
    20'd52325, 20'd55437, 20'd58733, 20'd62225, 20'd65926, 20'd69846, 20'd73999,
    20'd78399, 20'd83061, 20'd88000, 20'd93233, 20'd98777, 20'd104650, 20'd110873,
    20'd117466, 20'd124451, 20'd131851, 20'd139691, 20'd147998, 20'd156798,
    20'd166122, 20'd176000, 20'd186466, 20'd197553, 20'd209300, 20'd221746,
    20'd234932, 20'd248902, 20'd263702, 20'd279383, 20'd295996, 20'd313596,
    20'd332244, 20'd352000, 20'd372931, 20'd395107, 20'd418601, 20'd443492,
    20'd469864, 20'd497803, 20'd527404, 20'd558765, 20'd591991, 20'd627193,
    20'd664488, 20'd704000, 20'd745862, 20'd790213
  };

  function automatic logic [63:0] pitch_units(int idx);
    logic [63:0] c;
    c = 64'(CENTIHZ[idx]);
    return ((c << FreqFracBits) + 64'd50) / 64'd100;
  endfunction

  function automatic logic [63:0] log2_const(logic [63:0] x);
    int j;
    int k;
    int e;
    logic [63:0] m;
    logic [63:0] r;
    e = 0;
    for (j = 0; j < 63; j++) begin
      if ((x >> (j + 1)) != 64'd0) e = j + 1;
    end
    if (e <= 30) m = x << (30 - e);
    else m = x >> (e - 30);
    r = 64'(e) << LogFrac;
    for (k = LogFrac - 1; k >= 0; k--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r = r + (64'd1 << k);
      end
    end
    return r;
  endfunction

  function automatic search_tab_t build_search();
    search_tab_t t;
    int i;
    for (i = 0; i < TabDepth; i++) begin
      if (i <= LastNote) t[i] = FreqW'(pitch_units(i));
      else t[i] = '1;
    end
    return t;
  endfunction

  function automatic log_tab_t build_log();
    log_tab_t t;
    int i;
    for (i = 0; i < TabDepth; i++) begin
      if (i <= LastNote) t[i] = LogW'(log2_const(pitch_units(i)));
      else t[i] = '0;
    end
    return t;
  endfunction

  function automatic small_tab_t build_pc();
    small_tab_t t;
    int i;
    for (i = 0; i < TabDepth; i++) t[i] = 4'(i % 12);
    return t;
  endfunction

  function automatic small_tab_t build_oct();
    small_tab_t t;
    int i;
    for (i = 0; i < TabDepth; i++) t[i] = 4'(i / 12);
    return t;
  endfunction

  localparam search_tab_t SEARCH_TAB = build_search();
  localparam log_tab_t    LOG_TAB    = build_log();
  localparam small_tab_t  PC_TAB     = build_pc();
  localparam small_tab_t  OCT_TAB    = build_oct();

endpackage

>>> rtl/core/nearest_note_cents_from_frequency.sv
// a transaction passes the log2 stage registers, the cents register and the output register
// throughput: one transaction per cycle unless stalled; 24-stage log2 squaring pipeline
// a stalled output holds the whole pipeline in place
// reset (rst_ni low, asynchronous) clears all valid bits; the data registers are not reset
module nearest_note_cents_from_frequency (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [nnc_pkg::FreqW-1:0]     frequency_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [nnc_pkg::IdxW-1:0]      note_index_o,
  output logic [nnc_pkg::PcW-1:0]       pitch_class_o,
  output logic [nnc_pkg::OctW-1:0]      octave_o,
  output logic [nnc_pkg::PitchW-1:0]    defined_pitch_o,
  output logic [nnc_pkg::FreqW-1:0]     measured_pitch_o,
  output logic signed [nnc_pkg::CentsW-1:0] cents_sharp_o
);
  import nnc_pkg::*;

  localparam int NSq = LogFrac;

  logic adv;

  logic [NSq:0]        vld_q;
  logic [FreqW-1:0]    f_q   [NSq+1];
  logic [MantW-1:0]    m_q   [NSq+1];
  logic [ExpW-1:0]     e_q   [NSq+1];
  logic [LogFrac-1:0]  fr_q  [NSq+1];
  logic [IdxW-1:0]     idx_q [NSq+1];

  logic [FreqW-1:0]    f_d   [NSq+1];
  logic [MantW-1:0]    m_d   [NSq+1];
  logic [ExpW-1:0]     e_d   [NSq+1];
  logic [LogFrac-1:0]  fr_d  [NSq+1];
  logic [IdxW-1:0]     idx_d [NSq+1];

  logic [FreqW-1:0] fin;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // clamp and normalize, then one squaring round per stage,
  // binary search in the first stages
  always_comb begin
    logic [2*MantW-1:0] sq;
    logic [MantW:0]     t;
    logic [IdxW-1:0]    cand;
    if (frequency_i < FreqLo) fin = FreqLo;
    else if (frequency_i > FreqHi) fin = FreqHi;
    else fin = frequency_i;
    e_d[0] = '0;
    for (int j = 0; j < FreqW; j++) begin
      if (fin[j]) e_d[0] = ExpW'(j);
    end
    f_d[0]   = fin;
    m_d[0]   = MantW'({{(MantW - FreqW){1'b0}}, fin} << (ExpW'(MantW - 1) - e_d[0]));
    fr_d[0]  = '0;
    idx_d[0] = '0;
    for (int k = 1; k <= NSq; k++) begin
      f_d[k]   = f_q[k-1];
      e_d[k]   = e_q[k-1];
      fr_d[k]  = fr_q[k-1];
      idx_d[k] = idx_q[k-1];
      sq = m_q[k-1] * m_q[k-1];
      t  = sq[2*MantW-1:MantW-1];
      if (t[MantW]) begin
        m_d[k] = t[MantW:1];
        fr_d[k][LogFrac-k] = 1'b1;
      end else begin
        m_d[k] = t[MantW-1:0];
      end
      cand = '0;
      if (k <= IdxW) begin
        cand = idx_q[k-1] | (IdxW'(1) << (IdxW - k));
        if (SEARCH_TAB[cand] <= f_q[k-1]) idx_d[k] = cand;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSq-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= NSq; k++) begin
        f_q[k]   <= f_d[k];
        m_q[k]   <= m_d[k];
        e_q[k]   <= e_d[k];
        fr_q[k]  <= fr_d[k];
        idx_q[k] <= idx_d[k];
      end
    end
  end

  // cents for the found note and its upper neighbor
  logic [LogW-1:0]      lf;
  logic [IdxW-1:0]      idx0, idx1;
  logic signed [LogW:0] dlt0, dlt1;
  logic signed [CW-1:0] c0, c1;
  logic                 step;

  logic                 cv_q;
  logic signed [CW-1:0] c_q, c_d;
  logic [IdxW-1:0]      ci_q, ci_d;
  logic [FreqW-1:0]     cf_q;

  always_comb begin
    lf   = {e_q[NSq], fr_q[NSq]};
    idx0 = idx_q[NSq];
    idx1 = (idx0 == IdxW'(LastNote)) ? idx0 : idx0 + IdxW'(1);
    dlt0 = $signed({1'b0, lf}) - $signed({1'b0, LOG_TAB[idx0]});
    dlt1 = $signed({1'b0, lf}) - $signed({1'b0, LOG_TAB[idx1]});
    c0   = CW'(dlt0) * CW'(1200);
    c1   = CW'(dlt1) * CW'(1200);
    step = (c0 > (CW'(50) <<< LogFrac)) && (idx0 != IdxW'(LastNote));
    c_d  = step ? c1 : c0;
    ci_d = step ? idx1 : idx0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      cv_q        <= vld_q[NSq];
      out_valid_o <= cv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q  <= c_d;
      ci_q <= ci_d;
      cf_q <= f_q[NSq];
    end
  end

  // add one half, truncate toward zero, saturate
  logic signed [CW-1:0] tr, qr;
  logic signed [CentsW-1:0] q_d;

  always_comb begin
    tr = c_q + (CW'(1) <<< (LogFrac - 1));
    if (tr >= 0) qr = tr >>> LogFrac;
    else qr = -((-tr) >>> LogFrac);
    if (qr > CW'(16383)) q_d = CentsW'(16383);
    else if (qr < -CW'(16384)) q_d = CentsW'(-16384);
    else q_d = CentsW'(qr);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      note_index_o     <= ci_q;
      pitch_class_o    <= PC_TAB[ci_q];
      octave_o         <= OCT_TAB[ci_q];
      defined_pitch_o  <= SEARCH_TAB[ci_q][PitchW-1:0];
      measured_pitch_o <= cf_q;
      cents_sharp_o    <= q_d;
    end
  end

endmodule
